// ===== src/rtfx_pkg.sv =====
package rtfx_pkg;

	localparam int unsigned STORE_WORDS = 4096;
	localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
	localparam logic [31:0] STORE_LIMIT = 32'(STORE_WORDS);

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned OFFS_W  = 30;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RELOC = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Token type, taken from the top two bits of a token's first byte.
	typedef enum logic [1:0] {
		TOK_PAD  = 2'b00,
		TOK_ONE  = 2'b01,
		TOK_TWO  = 2'b10,
		TOK_FOUR = 2'b11
	} tok_t;

	localparam logic [1:0] LEFT_TWO  = 2'd1;
	localparam logic [1:0] LEFT_FOUR = 2'd3;

	// Request handed from the token parser to the store stage.
	typedef struct packed {
		logic                rd;        // store read issued
		logic                wr;        // plain word write
		logic                reloc;     // relocate the word read
		logic                rng_err;   // completed token left the store
		logic                show_idx;  // result carries an index
		logic [INDEX_W-1:0]  idx;
		logic [ADDR_W-1:0]   addr;
		logic [WORD_W-1:0]   data;
	} rtfx_req_t;

endpackage

// ===== src/relocation_table_fixup_core.sv =====
// Channel   Handshake              Word
// input     in_valid / in_stall    op, word_index, word_data, reloc_byte, last
// output    out_valid / out_stall  word_value, touched_index, patched, range_error
// config    cfg_valid / cfg_ready  base_address
//
// One item per cycle while in_stall is low; items pass the store stage, then the
// result register. The store is read as an item is accepted and written as it leaves
// the store stage; a read of an entry written in that cycle gets the new word by
// forwarding. Reset clears the cursor, token state and base_address, not the store.
// While out_stall holds a result the block takes at most one more item, then stalls.
module relocation_table_fixup_core import rtfx_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [INDEX_W-1:0]        word_index,
	input  logic signed [WORD_W-1:0]  word_data,
	input  logic [7:0]                reloc_byte,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [WORD_W-1:0]  word_value,
	output logic [INDEX_W-1:0]        touched_index,
	output logic                      patched,
	output logic                      range_error,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [WORD_W-1:0]         base_address
);

	logic [WORD_W-1:0] base_q;

	rtfx_req_t         req;
	rtfx_req_t         req_s1;
	logic              s1_valid_q;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_data_s1;

	logic              take;
	logic              s1_adv;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] new_word;
	logic              do_patch;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;

	logic               out_valid_q;
	logic [WORD_W-1:0]  value_q;
	logic [INDEX_W-1:0] index_q;
	logic               patched_q;
	logic               err_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= base_address;
		end
	end

	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !s1_adv;
	assign take     = in_valid && !in_stall;

	rtfx_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.op         (op),
		.word_index (word_index),
		.word_data  (word_data),
		.reloc_byte (reloc_byte),
		.last       (last),
		.req        (req)
	);

	rtfx_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req_s1.addr),
		.wdata (wr_data),
		.re    (take && req.rd),
		.raddr (req.addr),
		.rdata (rd_data)
	);

	// Zero and negative words count as already relocated.
	assign cur_word = fwd_s1 ? fwd_data_s1 : rd_data;
	assign do_patch = req_s1.reloc && (cur_word != '0) && !cur_word[WORD_W-1];
	assign new_word = cur_word + base_q;
	assign wr_en    = s1_valid_q && s1_adv && (req_s1.wr || do_patch);
	assign wr_data  = req_s1.wr ? req_s1.data : new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
			fwd_s1 <= wr_en && req.rd && (req.addr == req_s1.addr);
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
			fwd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			value_q <= req_s1.rd ? (do_patch ? new_word : cur_word) : '0;
			index_q <= req_s1.show_idx ? req_s1.idx : '0;
			patched_q <= do_patch;
			err_q <= req_s1.rng_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign word_value    = $signed(value_q);
	assign touched_index = index_q;
	assign patched       = patched_q;
	assign range_error   = err_q;

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q |-> !patched_q && value_q == '0 && index_q == '0)
		else $error("range error result carries word data");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(req_s1))
		else $error("stalled store stage lost its word");

	a_wr_owned: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> s1_valid_q && (req_s1.wr || req_s1.reloc))
		else $error("store written without a write or relocation in flight");

endmodule

// ===== src/rtfx_ram.sv =====
module rtfx_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/rtfx_parse.sv =====
module rtfx_parse import rtfx_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [1:0]               op,
	input  logic [INDEX_W-1:0]       word_index,
	input  logic signed [WORD_W-1:0] word_data,
	input  logic [7:0]               reloc_byte,
	input  logic                     last,
	output rtfx_req_t                req
);

	logic [WORD_W-1:0] cursor_q, cursor_n;
	logic [OFFS_W-1:0] pend_q, pend_n;
	logic [1:0]        left_q, left_n;

	logic [WORD_W-1:0] idx_ext;
	logic              idx_ok;
	logic [OFFS_W-1:0] pend_shift;
	logic [1:0]        left_dec;
	logic              fin;
	logic [OFFS_W-1:0] offs;
	logic [WORD_W-1:0] cur_sum;

	assign idx_ext    = WORD_W'(word_index);
	assign idx_ok     = idx_ext < STORE_LIMIT;
	assign pend_shift = {pend_q[OFFS_W-9:0], reloc_byte};
	assign left_dec   = left_q - 2'd1;

	always_comb begin
		fin = 1'b0;
		offs = '0;
		pend_n = pend_q;
		left_n = left_q;
		if (left_q != 2'd0) begin
			left_n = left_dec;
			if (left_dec == 2'd0) begin
				fin = 1'b1;
				offs = pend_shift;
				pend_n = '0;
			end else begin
				pend_n = pend_shift;
			end
		end else begin
			unique case (tok_t'(reloc_byte[7:6]))
				TOK_ONE: begin
					fin = 1'b1;
					offs = OFFS_W'(reloc_byte[5:0]);
				end
				TOK_TWO: begin
					pend_n = OFFS_W'(reloc_byte[5:0]);
					left_n = LEFT_TWO;
				end
				TOK_FOUR: begin
					pend_n = OFFS_W'(reloc_byte[5:0]);
					left_n = LEFT_FOUR;
				end
				TOK_PAD: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cur_sum = cursor_q + WORD_W'(offs);

	always_comb begin
		req = '0;
		req.data = $unsigned(word_data);
		unique case (op_t'(op))
			OP_WRITE: begin
				req.wr = idx_ok;
				req.addr = idx_ext[ADDR_W-1:0];
			end
			OP_READ: begin
				req.rd = idx_ok;
				req.show_idx = 1'b1;
				req.idx = word_index;
				req.addr = idx_ext[ADDR_W-1:0];
			end
			OP_RELOC: begin
				if (fin) begin
					if (cur_sum >= STORE_LIMIT) begin
						req.rng_err = 1'b1;
					end else begin
						req.rd = 1'b1;
						req.reloc = 1'b1;
						req.show_idx = 1'b1;
						req.idx = cur_sum[INDEX_W-1:0];
						req.addr = cur_sum[ADDR_W-1:0];
					end
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			pend_q <= '0;
			left_q <= '0;
		end else if (take && op_t'(op) == OP_RELOC) begin
			if (last) begin
				// The chunk ends here: any unfinished token is dropped.
				cursor_q <= '0;
				pend_q <= '0;
				left_q <= '0;
			end else begin
				cursor_q <= fin ? cur_sum : cursor_q;
				pend_q <= pend_n;
				left_q <= left_n;
			end
		end
	end

endmodule
